[hdl/rcbp_pkg.sv]
// Shared types, constants and the size class function of the buffer pool.
package rcbp_pkg;

  localparam int HANDLE_W = 10;
  localparam int LEN_W    = 24;
  localparam int CNT_W    = 16;
  localparam int CLS_W    = 5;
  localparam int TOTAL_W  = 32;

  localparam int NUM_BUFFERS_DEF = 1024;
  localparam int NUM_CLASSES_DEF = 32;
  localparam int LENGTH_BITS_DEF = 24;

  localparam logic [CNT_W-1:0] MAX_COUNT = 16'hFFFF;
  localparam logic [CLS_W-1:0] MIN_CLASS = 5'd4;
  localparam int               HDR_BYTES = 16;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_RETAIN  = 2'd2,
    REQ_RESIZE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_NOT_INUSE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_ALLOC,
    ST_POP,
    ST_REL
  } st_e;

  typedef struct packed {
    req_e                req_type;
    logic [LEN_W-1:0]    length;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] result_handle;
    logic [CLS_W-1:0]    size_class;
    logic                recycled;
    logic [CNT_W-1:0]    ref_count;
    logic                buffer_freed;
    logic [TOTAL_W-1:0]  total_bytes;
  } res_t;

  // 4 plus the bit length of (len+15)>>4
  localparam int QW = LEN_W - 3;

  function automatic logic [CLS_W-1:0] class_of(logic [LEN_W-1:0] len);
    logic [LEN_W:0]   q;
    logic [CLS_W-1:0] c;
    q = (LEN_W+1)'((LEN_W+1)'(len) + (LEN_W+1)'(15)) >> 4;
    c = MIN_CLASS;
    for (int i = 0; i < QW; i++) begin
      if (q[i]) c = CLS_W'(i + 5);
    end
    return c;
  endfunction

endpackage

[hdl/rcbp_entry_ram.sv]
// Per-buffer entry memory: one write port, one read port with registered data.
module rcbp_entry_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[hdl/refcounted_size_class_buffer_pool_top.sv]
// Top level of the reference counted size class buffer pool.
// done_o is registered from the last state of each path: CHK for release, retain, fitting resize and
// a handle not in use; ALLOC for a fresh or exhausted allocate; POP for a free-list allocate; ALLOC for
// an exhausted growing resize; REL for a growing resize. A new request waits, busy high, until the last is done.
// Reset clears counters and list valid bits; a fill count stands in for clearing the entry RAM.
// The receiver cannot stall.
module refcounted_size_class_buffer_pool_top #(
  parameter int NUM_BUFFERS = rcbp_pkg::NUM_BUFFERS_DEF,
  parameter int NUM_CLASSES = rcbp_pkg::NUM_CLASSES_DEF,
  parameter int LENGTH_BITS = rcbp_pkg::LENGTH_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rcbp_pkg::req_t req_i,
  output rcbp_pkg::res_t res_o,
  output logic           done_o
);

  localparam int IW = $clog2(NUM_BUFFERS);
  localparam int FW = IW + 1;
  localparam int CW = $clog2(NUM_CLASSES);

  typedef struct packed {
    logic [rcbp_pkg::CLS_W-1:0] cls;
    logic [rcbp_pkg::CNT_W-1:0] cnt;
    logic [FW-1:0]              link;
  } entry_t;

  localparam int DW = $bits(entry_t);

  rcbp_pkg::st_e  state_q, state_d;
  rcbp_pkg::req_t req_q;
  logic [rcbp_pkg::CLS_W-1:0]   cls_q;
  entry_t                       old_q, old_d;
  logic [FW-1:0]                fresh_q, fresh_d;
  logic [rcbp_pkg::TOTAL_W-1:0] total_q, total_d;
  logic [IW-1:0]                newh_q, newh_d;
  logic                         recyc_q, recyc_d;
  logic [IW-1:0]                heads_q [NUM_CLASSES];
  logic [IW-1:0]                heads_d [NUM_CLASSES];
  logic [NUM_CLASSES-1:0]       hvalid_q, hvalid_d;
  rcbp_pkg::res_t               res_q, res_d;
  logic                         done_q, done_d;

  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;
  logic [DW-1:0] mem_rdata;
  entry_t        rd_entry;

  rcbp_entry_ram #(
    .DEPTH (NUM_BUFFERS),
    .AW    (IW),
    .DW    (DW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_entry = entry_t'(mem_rdata);

  logic                         accept;
  logic [rcbp_pkg::LEN_W-1:0]   len_mask;
  logic [rcbp_pkg::CLS_W-1:0]   cls_in;
  logic [IW-1:0]                hidx;
  logic [CW-1:0]                cidx;
  logic                         hin, fits, cls_ok, fresh_ok, hv;
  logic [32:0]                  payload;

  assign accept   = start && !busy;
  assign len_mask = (LENGTH_BITS >= rcbp_pkg::LEN_W) ? '1 :
                    rcbp_pkg::LEN_W'((32'd1 << LENGTH_BITS) - 32'd1);
  assign cls_in   = rcbp_pkg::class_of(req_i.length & len_mask);
  assign hidx     = IW'(req_q.handle);
  assign cidx     = cls_q[CW-1:0];

  // never-allocated entries read as count zero through the fill count
  assign hin = (17'(req_q.handle) < 17'(NUM_BUFFERS)) && (FW'(hidx) < fresh_q) &&
               (rd_entry.cnt != '0);
  assign payload = (33'd1 << rd_entry.cls) - 33'(rcbp_pkg::HDR_BYTES);
  assign fits    = (rd_entry.cls < rcbp_pkg::MIN_CLASS) || (33'(req_q.length) <= payload);
  assign cls_ok   = 6'(cls_q) < 6'(NUM_CLASSES);
  assign fresh_ok = fresh_q < FW'(NUM_BUFFERS);
  assign hv       = hvalid_q[cidx];

  // release of the entry read in CHK, or of the saved old entry on a growing resize
  entry_t                     rel_src, rel_entry;
  logic [rcbp_pkg::CNT_W-1:0] rel_cnt;
  logic                       rel_freed;
  logic [rcbp_pkg::CLS_W-1:0] pcls;
  logic [CW-1:0]              pidx;

  always_comb begin
    rel_src   = (state_q == rcbp_pkg::ST_REL) ? old_q : rd_entry;
    rel_freed = (rel_src.cnt != rcbp_pkg::MAX_COUNT) && (rel_src.cnt == 16'd1);
    rel_cnt   = (rel_src.cnt == rcbp_pkg::MAX_COUNT) ? rel_src.cnt : rel_src.cnt - 16'd1;
    pcls      = (6'(rel_src.cls) >= 6'(NUM_CLASSES)) ? '0 : rel_src.cls;
    pidx      = CW'(pcls);
    rel_entry      = rel_src;
    rel_entry.cnt  = rel_cnt;
    if (rel_freed) begin
      rel_entry.link = hvalid_q[pidx] ? FW'(heads_q[pidx]) : FW'(NUM_BUFFERS);
    end
  end

  assign busy = (state_q != rcbp_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rcbp_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (req_i.req_type == rcbp_pkg::REQ_ALLOC) ? rcbp_pkg::ST_ALLOC :
                                                             rcbp_pkg::ST_CHK;
        end
      end
      rcbp_pkg::ST_CHK: begin
        if (hin && req_q.req_type == rcbp_pkg::REQ_RESIZE && !fits) begin
          state_d = rcbp_pkg::ST_ALLOC;
        end else begin
          state_d = rcbp_pkg::ST_IDLE;
        end
      end
      rcbp_pkg::ST_ALLOC: begin
        if (!cls_ok) begin
          state_d = rcbp_pkg::ST_IDLE;
        end else if (hv) begin
          state_d = rcbp_pkg::ST_POP;
        end else if (fresh_ok && req_q.req_type == rcbp_pkg::REQ_RESIZE) begin
          state_d = rcbp_pkg::ST_REL;
        end else begin
          state_d = rcbp_pkg::ST_IDLE;
        end
      end
      rcbp_pkg::ST_POP: begin
        state_d = (req_q.req_type == rcbp_pkg::REQ_RESIZE) ? rcbp_pkg::ST_REL :
                                                            rcbp_pkg::ST_IDLE;
      end
      rcbp_pkg::ST_REL: begin
        state_d = rcbp_pkg::ST_IDLE;
      end
      default: begin
        state_d = rcbp_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath, memory access and result
  always_comb begin
    old_d     = old_q;
    fresh_d   = fresh_q;
    total_d   = total_q;
    newh_d    = newh_q;
    recyc_d   = recyc_q;
    heads_d   = heads_q;
    hvalid_d  = hvalid_q;
    res_d     = res_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = hidx;
    mem_wdata = rel_entry;
    mem_raddr = hidx;

    case (state_q)
      rcbp_pkg::ST_IDLE: begin
        mem_raddr = IW'(req_i.handle);
      end
      rcbp_pkg::ST_CHK: begin
        res_d             = '0;
        res_d.total_bytes = total_q;
        if (!hin) begin
          res_d.status = rcbp_pkg::STAT_NOT_INUSE;
          done_d       = 1'b1;
        end else begin
          case (req_q.req_type)
            rcbp_pkg::REQ_RELEASE: begin
              mem_we    = 1'b1;
              mem_wdata = rel_entry;
              if (rel_freed) begin
                heads_d[pidx]  = hidx;
                hvalid_d[pidx] = 1'b1;
              end
              res_d.status        = rcbp_pkg::STAT_OK;
              res_d.result_handle = req_q.handle;
              res_d.size_class    = rd_entry.cls;
              res_d.ref_count     = rel_cnt;
              res_d.buffer_freed  = rel_freed;
              done_d              = 1'b1;
            end
            rcbp_pkg::REQ_RETAIN: begin
              mem_we        = 1'b1;
              mem_wdata     = rd_entry;
              if (rd_entry.cnt != rcbp_pkg::MAX_COUNT) begin
                mem_wdata.cnt = rd_entry.cnt + 16'd1;
              end
              res_d.status        = rcbp_pkg::STAT_OK;
              res_d.result_handle = req_q.handle;
              res_d.size_class    = rd_entry.cls;
              res_d.ref_count     = mem_wdata.cnt;
              done_d              = 1'b1;
            end
            rcbp_pkg::REQ_RESIZE: begin
              old_d = rd_entry;
              if (fits) begin
                res_d.status        = rcbp_pkg::STAT_OK;
                res_d.result_handle = req_q.handle;
                res_d.size_class    = rd_entry.cls;
                res_d.ref_count     = rd_entry.cnt;
                done_d              = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      rcbp_pkg::ST_ALLOC: begin
        mem_raddr = heads_q[cidx];
        if (!cls_ok || (!hv && !fresh_ok)) begin
          res_d             = '0;
          res_d.status      = rcbp_pkg::STAT_EXHAUSTED;
          res_d.size_class  = cls_q;
          res_d.total_bytes = total_q;
          done_d            = 1'b1;
        end else if (!hv) begin
          mem_we         = 1'b1;
          mem_waddr      = IW'(fresh_q);
          mem_wdata.cls  = cls_q;
          mem_wdata.cnt  = 16'd1;
          mem_wdata.link = '0;
          fresh_d        = fresh_q + FW'(1);
          total_d        = total_q + (32'd1 << cls_q);
          newh_d         = IW'(fresh_q);
          recyc_d        = 1'b0;
          if (req_q.req_type != rcbp_pkg::REQ_RESIZE) begin
            res_d               = '0;
            res_d.status        = rcbp_pkg::STAT_OK;
            res_d.result_handle = rcbp_pkg::HANDLE_W'(fresh_q);
            res_d.size_class    = cls_q;
            res_d.ref_count     = 16'd1;
            res_d.total_bytes   = total_d;
            done_d              = 1'b1;
          end
        end
      end
      rcbp_pkg::ST_POP: begin
        // rd_entry holds the popped head's entry
        if (rd_entry.link < FW'(NUM_BUFFERS)) begin
          heads_d[cidx] = IW'(rd_entry.link);
        end else begin
          hvalid_d[cidx] = 1'b0;
        end
        mem_we         = 1'b1;
        mem_waddr      = heads_q[cidx];
        mem_wdata.cls  = cls_q;
        mem_wdata.cnt  = 16'd1;
        mem_wdata.link = rd_entry.link;
        newh_d         = heads_q[cidx];
        recyc_d        = 1'b1;
        if (req_q.req_type != rcbp_pkg::REQ_RESIZE) begin
          res_d               = '0;
          res_d.status        = rcbp_pkg::STAT_OK;
          res_d.result_handle = rcbp_pkg::HANDLE_W'(heads_q[cidx]);
          res_d.size_class    = cls_q;
          res_d.recycled      = 1'b1;
          res_d.ref_count     = 16'd1;
          res_d.total_bytes   = total_q;
          done_d              = 1'b1;
        end
      end
      rcbp_pkg::ST_REL: begin
        // old buffer release after the new one is taken
        mem_we    = 1'b1;
        mem_waddr = hidx;
        mem_wdata = rel_entry;
        if (rel_freed) begin
          heads_d[pidx]  = hidx;
          hvalid_d[pidx] = 1'b1;
        end
        res_d.status        = rcbp_pkg::STAT_OK;
        res_d.result_handle = rcbp_pkg::HANDLE_W'(newh_q);
        res_d.size_class    = cls_q;
        res_d.recycled      = recyc_q;
        res_d.ref_count     = 16'd1;
        res_d.buffer_freed  = rel_freed;
        res_d.total_bytes   = total_q;
        done_d              = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rcbp_pkg::ST_IDLE;
      fresh_q  <= '0;
      total_q  <= '0;
      hvalid_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fresh_q  <= fresh_d;
      total_q  <= total_d;
      hvalid_q <= hvalid_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      cls_q <= cls_in;
    end
    old_q   <= old_d;
    newh_q  <= newh_d;
    recyc_q <= recyc_d;
    heads_q <= heads_d;
    res_q   <= res_d;
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule
